@@ sv/ilt_pkg.sv @@
package ilt_pkg;

    // request codes
    localparam logic [2:0] OP_GET       = 3'd0;
    localparam logic [2:0] OP_INS_FRONT = 3'd1;
    localparam logic [2:0] OP_APPEND    = 3'd2;
    localparam logic [2:0] OP_INS_AT    = 3'd3;
    localparam logic [2:0] OP_DELETE    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 7;
    localparam int LEN_W  = 7;

    // fan-in of one read reduction stage
    localparam int OR_FAN = 8;

    typedef struct packed {
        logic [2:0]               op;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [1:0]               status;
        logic [LEN_W-1:0]         length;
    } rsp_t;

    // broadcast command to every cell
    typedef struct packed {
        logic ins;
        logic del;
        logic rd;
    } cell_ctl_t;

    // request bookkeeping that rides beside the read reduction
    typedef struct packed {
        logic             valid;
        logic [1:0]       status;
        logic [LEN_W-1:0] length;
    } trk_t;

endpackage

@@ sv/ilt_cell.sv @@
module ilt_cell #(
    parameter int CW  = 7,
    parameter int POS = 0
) (
    input  logic                          clk,
    input  ilt_pkg::cell_ctl_t            ctl,
    input  logic [CW-1:0]                 pos,
    input  logic [CW-1:0]                 rd_pos,
    input  logic signed [ilt_pkg::DATA_W-1:0] value,
    input  logic signed [ilt_pkg::DATA_W-1:0] left,
    input  logic signed [ilt_pkg::DATA_W-1:0] right,
    output logic signed [ilt_pkg::DATA_W-1:0] data,
    output logic signed [ilt_pkg::DATA_W-1:0] hit_val
);
    import ilt_pkg::*;

    localparam logic [CW-1:0] MY_POS = CW'(POS);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (MY_POS == pos)
                data_next = value;
            else if (MY_POS > pos)
                data_next = left;
        end
        else if (ctl.del && (MY_POS >= pos))
        begin
            data_next = right;
        end
    end

    // element word: no reset, contents are meaningful only below the count
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign hit_val = (ctl.rd && (MY_POS == rd_pos)) ? data_reg : '0;

endmodule

@@ sv/ilt_or_stage.sv @@
module ilt_or_stage #(
    parameter int N_IN = 64,
    parameter int W    = 32
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din [N_IN],
    output logic [W-1:0] dout [(N_IN + ilt_pkg::OR_FAN - 1) / ilt_pkg::OR_FAN]
);
    import ilt_pkg::*;

    localparam int N_OUT = (N_IN + OR_FAN - 1) / OR_FAN;

    logic [W-1:0] grp_next [N_OUT];
    logic [W-1:0] grp_reg  [N_OUT];

    always_comb
    begin
        for (int g = 0; g < N_OUT; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < OR_FAN; k++)
            begin
                if (g * OR_FAN + k < N_IN)
                    grp_next[g] = grp_next[g] | din[g * OR_FAN + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            grp_reg <= grp_next;
    end

    assign dout = grp_reg;

endmodule

@@ sv/indexed_list_table.sv @@
// Response path: the tracking registers carry status and length beside the read
// reduction and land in the response register, which drives rsp_valid and rsp.
// Throughput: one request per cycle; the shifting cell row applies any insert or
// delete in the cycle of acceptance, and the read path is a four-stage OR reduction.
// The whole pipeline holds while a response waits under stall. Reset (rst_n, async,
// active low) clears the length and the tracking line; element words are not reset.
module indexed_list_table #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ilt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ilt_pkg::rsp_t rsp
);
    import ilt_pkg::*;

    // count width holds CAPACITY itself; XW covers both count and index
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // word counts through the read reduction tree
    localparam int N1 = (CAPACITY + OR_FAN - 1) / OR_FAN;
    localparam int N2 = (N1 + OR_FAN - 1) / OR_FAN;
    localparam int N3 = (N2 + OR_FAN - 1) / OR_FAN;
    localparam int N4 = (N3 + OR_FAN - 1) / OR_FAN;

    // ---------------------------------------------------------------
    // Flow control: the pipeline advances as a whole unless the
    // response register is full and stalled.
    // ---------------------------------------------------------------
    trk_t trk_reg [3];
    trk_t out_reg;
    logic advance;
    logic accept;

    assign advance   = !(out_reg.valid && rsp_stall);
    assign req_stall = !advance;
    assign accept    = req_valid && advance;

    // ---------------------------------------------------------------
    // Request decode against the current length
    // ---------------------------------------------------------------
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] len_x;
    logic          full;
    logic [1:0]    status;
    cell_ctl_t     ctl;
    logic [CW-1:0] pos;

    assign idx_x = XW'(req.index);
    assign cnt_x = XW'(count_reg);
    assign full  = (count_reg == CAP_C);

    always_comb
    begin
        status  = ST_RANGE;
        ctl     = '0;
        pos     = '0;
        unique case (req.op)
            OP_GET:
            begin
                pos = CW'(req.index);
                if (idx_x < cnt_x)
                begin
                    status = ST_OK;
                    ctl.rd = 1'b1;
                end
            end
            OP_INS_FRONT:
            begin
                pos = '0;
                if (full)
                    status = ST_FULL;
                else
                begin
                    status  = ST_OK;
                    ctl.ins = 1'b1;
                end
            end
            OP_APPEND:
            begin
                pos = count_reg;
                if (full)
                    status = ST_FULL;
                else
                begin
                    status  = ST_OK;
                    ctl.ins = 1'b1;
                end
            end
            OP_INS_AT:
            begin
                pos = CW'(req.index);
                if (idx_x > cnt_x)
                    status = ST_RANGE;
                else if (full)
                    status = ST_FULL;
                else
                begin
                    status  = ST_OK;
                    ctl.ins = 1'b1;
                end
            end
            OP_DELETE:
            begin
                pos = CW'(req.index);
                if (idx_x < cnt_x)
                begin
                    status  = ST_OK;
                    ctl.del = 1'b1;
                end
            end
            default:
            begin
                status = ST_RANGE;
            end
        endcase
    end

    // drop the command unless the request is actually taken
    cell_ctl_t cell_ctl;
    assign cell_ctl = accept ? ctl : '0;

    always_comb
    begin
        count_next = count_reg;
        if (cell_ctl.ins)
            count_next = count_reg + CW'(1);
        else if (cell_ctl.del)
            count_next = count_reg - CW'(1);
    end

    assign len_x = XW'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // ---------------------------------------------------------------
    // Row of cells: each holds one position and takes its neighbour's
    // word on a shift.
    // ---------------------------------------------------------------
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0]        hit_vals  [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_w;
        logic signed [DATA_W-1:0] right_w;
        logic signed [DATA_W-1:0] hit_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        ilt_cell #(
            .CW  (CW),
            .POS (i)
        ) u_cell (
            .clk     (clk),
            .ctl     (cell_ctl),
            .pos     (pos),
            .rd_pos  (pos),
            .value   (req.value),
            .left    (left_w),
            .right   (right_w),
            .data    (cell_data[i]),
            .hit_val (hit_w)
        );

        assign hit_vals[i] = hit_w;
    end

    // ---------------------------------------------------------------
    // Read reduction: only the addressed cell drives non-zero, so an
    // OR tree gathers it. Four registered stages.
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] red1 [N1];
    logic [DATA_W-1:0] red2 [N2];
    logic [DATA_W-1:0] red3 [N3];
    logic [DATA_W-1:0] red4 [N4];

    ilt_or_stage #(.N_IN(CAPACITY), .W(DATA_W)) u_or1
        (.clk(clk), .en(advance), .din(hit_vals), .dout(red1));
    ilt_or_stage #(.N_IN(N1), .W(DATA_W)) u_or2
        (.clk(clk), .en(advance), .din(red1), .dout(red2));
    ilt_or_stage #(.N_IN(N2), .W(DATA_W)) u_or3
        (.clk(clk), .en(advance), .din(red2), .dout(red3));
    ilt_or_stage #(.N_IN(N3), .W(DATA_W)) u_or4
        (.clk(clk), .en(advance), .din(red3), .dout(red4));

    // ---------------------------------------------------------------
    // Status and length track the read data through three stages,
    // then land in the response register.
    // ---------------------------------------------------------------
    trk_t trk_in;

    assign trk_in = '{valid: accept, status: status, length: len_x[LEN_W-1:0]};

    // advance the tracking line with the read reduction, hold under stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 3; s++)
                trk_reg[s] <= '0;
            out_reg <= '0;
        end
        else if (advance)
        begin
            trk_reg[0] <= trk_in;
            trk_reg[1] <= trk_reg[0];
            trk_reg[2] <= trk_reg[1];
            out_reg    <= trk_reg[2];
        end
    end

    assign rsp_valid = out_reg.valid;
    assign rsp       = '{read_value: $signed(red4[0]),
                         status: out_reg.status,
                         length: out_reg.length};

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("element count beyond capacity");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("element count moved without a request");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (status == ST_FULL) |=> $stable(count_reg))
        else $error("dropped insert changed the count");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> (rsp.read_value == 0))
        else $error("failed request returned a non-zero value");

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ilt_pkg::*;

    localparam int          LIST_CAP     = 64;
    localparam int          CLK_PERIOD   = 20;
    localparam int          RESET_CYCLES = 6;
    // Random requests per idling phase; four phases give about 1150 requests.
    localparam int unsigned PHASE_ITEMS  = 288;
    // Idle cycles before closing out, allowing for the pipeline depth and a little more.
    localparam int          SETTLE_CYCLES = 12;
    // Longest run of cycles with no request or response accepted before giving up.
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int          SHOW_LIMIT   = 10;

    // Op codes that the block does not implement; each must come back as a range error.
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    // Mirror of the list contents plus the queue of responses still owed by the block.
    class list_scoreboard;
        logic signed [DATA_W-1:0] mirror_cells[$];
        rsp_t                     awaited_rsps[$];
        int unsigned              capacity;
        int unsigned              mismatches;

        function new(int unsigned cap);
            capacity   = cap;
            mismatches = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
                $display("%s", msg);
        endfunction

        // Range is checked before fullness, as the block does.
        function logic [1:0] place(int unsigned pos, logic signed [DATA_W-1:0] v);
            if (pos > mirror_cells.size())
                return ST_RANGE;
            if (mirror_cells.size() >= capacity)
                return ST_FULL;
            mirror_cells.insert(pos, v);
            return ST_OK;
        endfunction

        function void accept_request(req_t r);
            rsp_t        e;
            int unsigned held;
            held         = mirror_cells.size();
            e.read_value = '0;
            e.status     = ST_OK;
            case (r.op)
                OP_GET:
                    if (r.index < held)
                        e.read_value = mirror_cells[r.index];
                    else
                        e.status = ST_RANGE;
                OP_INS_FRONT: e.status = place(0, r.value);
                OP_APPEND:    e.status = place(held, r.value);
                OP_INS_AT:    e.status = place(r.index, r.value);
                OP_DELETE:
                    if (r.index < held)
                        mirror_cells.delete(r.index);
                    else
                        e.status = ST_RANGE;
                default:      e.status = ST_RANGE;
            endcase
            e.length = LEN_W'(mirror_cells.size());
            awaited_rsps.push_back(e);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (awaited_rsps.size() == 0)
            begin
                flag($sformatf("response with none outstanding: value %0d status %0d length %0d",
                               got.read_value, got.status, got.length));
                return;
            end
            e = awaited_rsps.pop_front();
            if (got.read_value !== e.read_value || got.status !== e.status
                || got.length !== e.length)
                flag($sformatf({"response mismatch: expected value %0d status %0d length %0d,",
                                " got value %0d status %0d length %0d"},
                               e.read_value, e.status, e.length,
                               got.read_value, got.status, got.length));
        endfunction

        function int unsigned pending();
            return awaited_rsps.size();
        endfunction

        function void close_out();
            if (awaited_rsps.size() != 0)
                flag($sformatf("%0d responses never arrived", awaited_rsps.size()));
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    list_scoreboard board;
    int unsigned    quiet_cycles  = 0;
    int unsigned    send_idle_pct = 0;
    int unsigned    stall_pct     = 0;

    indexed_list_table #(
        .CAPACITY (LIST_CAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Draw a fresh stall decision every cycle so stalls land on every pipeline phase.
    always @(negedge clk)
    begin
        rsp_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Sample both handshakes at the rising edge: check any response before noting
    // the request of the same edge, so a response can never match its own request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp);
            if (req_valid && !req_stall)
                board.accept_request(req);
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: abandon the run when nothing moves for too long.
    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one request, starting at a falling edge: insert random idle cycles first,
    // then hold the payload steady until it is taken at a rising edge.
    task automatic drive_request(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                                 input logic signed [DATA_W-1:0] val);
        req_t r;
        r.op    = op;
        r.index = idx;
        r.value = val;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    // Random traffic in stints that lean towards growing, mixing or shrinking the list,
    // so that both the full and the empty corner are reached over and over.
    task automatic run_random(input int unsigned count);
        int unsigned              sent;
        int unsigned              stint;
        int unsigned              ins_pct;
        int unsigned              roll;
        int unsigned              held;
        int unsigned              mode;
        logic [2:0]               op;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        sent = 0;
        mode = 0;
        while (sent < count)
        begin
            stint   = $urandom_range(60, 140);
            ins_pct = (mode == 0) ? 70 : (mode == 1) ? 40 : 15;
            for (int unsigned k = 0; k < stint && sent < count; k++)
            begin
                held = board.mirror_cells.size();
                roll = $urandom_range(99);
                if (roll < 4)
                    op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
                else if (roll < 4 + ins_pct)
                    case ($urandom_range(2))
                        0:       op = OP_INS_FRONT;
                        1:       op = OP_APPEND;
                        default: op = OP_INS_AT;
                    endcase
                else if ($urandom_range(1) == 1)
                    op = OP_DELETE;
                else
                    op = OP_GET;
                // Mostly aim at live positions and the append slot; sometimes anywhere.
                if ($urandom_range(4) == 0)
                    idx = IDX_W'($urandom_range(127));
                else
                    idx = IDX_W'($urandom_range(held));
                if ($urandom_range(9) == 0)
                    case ($urandom_range(3))
                        0:       val = VAL_MAX;
                        1:       val = VAL_MIN;
                        2:       val = '0;
                        default: val = '1;
                    endcase
                else
                    val = $urandom;
                drive_request(op, idx, val);
                sent++;
            end
            mode = (mode + 1) % 3;
        end
    endtask

    initial
    begin : main
        board = new(LIST_CAP);
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phases: no idling, sender mostly idle, receiver mostly stalling, both a little.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 88; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 88; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase

            if (p == 0)
            begin
                // Empty list: every indexed request misses, insert past the end misses.
                drive_request(OP_GET,       7'd0,   32'sd9);
                drive_request(OP_DELETE,    7'd0,   32'sd9);
                drive_request(OP_INS_AT,    7'd1,   32'sd9);
                // Build a short list through every insert flavour.
                drive_request(OP_INS_AT,    7'd0,   32'sd5);
                drive_request(OP_APPEND,    7'd127, VAL_MAX);
                drive_request(OP_INS_FRONT, 7'd127, VAL_MIN);
                drive_request(OP_INS_AT,    7'd3,   '1);      // index equal to length appends
                drive_request(OP_INS_AT,    7'd1,   '0);
                // Read every live position and two past the end, then the top index.
                for (int i = 0; i < 7; i++)
                    drive_request(OP_GET, IDX_W'(i), 32'sd0);
                drive_request(OP_GET,       7'd127, 32'sd0);
                drive_request(OP_DELETE,    7'd127, 32'sd0);
                drive_request(OP_INS_AT,    7'd127, 32'sd1);
                // Unused op codes with every payload bit set.
                drive_request(OP_SPARE_A,   7'd127, '1);
                drive_request(OP_SPARE_B,   7'd127, '1);
                drive_request(OP_SPARE_C,   7'd127, '1);
                // Delete from the middle and the front, then read the new head.
                drive_request(OP_DELETE,    7'd2,   32'sd0);
                drive_request(OP_DELETE,    7'd0,   32'sd0);
                drive_request(OP_GET,       7'd0,   32'sd0);
            end

            run_random(PHASE_ITEMS);

            // Drop valid and hold off until every outstanding response is back.
            req_valid <= 1'b0;
            while (board.pending() != 0)
                @(negedge clk);
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        board.close_out();
        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
